// ===== hw/rtl/cnsd_pkg.sv =====
package cnsd_pkg;

  localparam int unsigned MagicLen   = 6;
  localparam int unsigned TrailerLen = 11;

  localparam logic [7:0] MagicPat [MagicLen] = '{8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31};

  // "TRAILER!!!" and its NUL
  localparam logic [7:0] TrailerPat [TrailerLen] = '{
    8'h54, 8'h52, 8'h41, 8'h49, 8'h4c, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21, 8'h00
  };

  localparam logic [3:0] FieldFileSize = 4'd6;
  localparam logic [3:0] FieldNameSize = 4'd11;
  localparam logic [3:0] FieldLast     = 4'd12;

  localparam logic [2:0] KindDigit     = 3'd0;
  localparam logic [2:0] KindFieldDone = 3'd1;
  localparam logic [2:0] KindNameByte  = 3'd2;
  localparam logic [2:0] KindNamePad   = 3'd3;
  localparam logic [2:0] KindDataByte  = 3'd4;
  localparam logic [2:0] KindDataPad   = 3'd5;
  localparam logic [2:0] KindEnded     = 3'd6;
  localparam logic [2:0] KindError     = 3'd7;

  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrBadMagic  = 2'd1;
  localparam logic [1:0] ErrBadDigit  = 2'd2;
  localparam logic [1:0] ErrNameLong  = 2'd3;

  typedef enum logic [5:0] {
    PhHeader = 6'b000001,
    PhName   = 6'b000010,
    PhData   = 6'b000100,
    PhPad    = 6'b001000,
    PhEnded  = 6'b010000,
    PhError  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  field_index;
    logic [31:0] value;
    logic        is_trailer;
    logic [1:0]  error_code;
  } result_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cpio_newc_stream_deframer_top.sv =====
// cpio newc deframer: takes archive bytes and returns one classified result
// per byte, in the cycle after the byte's transfer. The whole parse step for
// a byte is one pass of counter and compare logic into a single output
// register, so a byte is accepted every cycle the output register is empty
// or being drained; sustained rate is one byte per clock while the output is
// not stalled. A bad magic, a non-hex header digit or a name region over
// MAX_NAME_REGION latches an error reported on every later byte until reset;
// after the trailer entry every byte is reported as ended.
module cpio_newc_stream_deframer_top #(
  parameter int unsigned MAX_NAME_REGION = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [3:0] field_index, [35:4] value,
                                        // [37:36] error_code, [39:38] zero
  output logic [2:0]  m_axis_tuser_o,   // [2:0] kind
  output logic        m_axis_tlast_o    // is_trailer
);

  logic              step;
  logic              out_valid_q;
  cnsd_pkg::result_t res;
  cnsd_pkg::result_t out_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;

  cnsd_parser #(
    .MAX_NAME_REGION(MAX_NAME_REGION)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (s_axis_tdata_i),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.error_code, out_q.value, out_q.field_index};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.is_trailer;

endmodule

// ===== hw/rtl/cnsd_parser.sv =====
module cnsd_parser #(
  parameter int unsigned MAX_NAME_REGION = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output cnsd_pkg::result_t   result_o
);

  localparam int unsigned RW = $clog2(MAX_NAME_REGION + 1);

  cnsd_pkg::phase_e phase_q, phase_d;
  logic [6:0]    header_pos_q, header_pos_d;
  logic [31:0]   hex_accum_q, hex_accum_d;
  logic [31:0]   name_length_q, name_length_d;
  logic [RW-1:0] region_left_q, region_left_d;
  logic [RW-1:0] name_seen_q, name_seen_d;
  logic [31:0]   data_left_q, data_left_d;
  logic [1:0]    pad_left_q, pad_left_d;
  logic          trailer_match_q, trailer_match_d;
  logic [1:0]    error_kind_q, error_kind_d;

  logic [4:0]    hex;
  logic [6:0]    hdr_k;
  logic [31:0]   accum_next;
  logic [33:0]   fsz;
  logic [RW-1:0] region_dec;
  logic [31:0]   data_dec;
  logic [1:0]    raise;
  logic          tm_next;
  logic [1:0]    pad_after_name;

  always_comb begin
    hex            = cnsd_pkg::hex_digit(byte_i);
    hdr_k          = header_pos_q - 7'd6;
    accum_next     = {hex_accum_q[27:0], hex[3:0]};
    fsz            = (({2'b00, name_length_q} + 34'd1) & ~34'd3) + 34'd2;
    region_dec     = (region_left_q != '0) ? region_left_q - RW'(1) : '0;
    data_dec       = (data_left_q != '0) ? data_left_q - 32'd1 : '0;
    pad_after_name = 2'(32'd0 - data_left_q);
    tm_next        = trailer_match_q;
    if (name_seen_q < RW'(cnsd_pkg::TrailerLen) &&
        byte_i != cnsd_pkg::TrailerPat[name_seen_q[3:0]]) begin
      tm_next = 1'b0;
    end

    phase_d         = phase_q;
    header_pos_d    = header_pos_q;
    hex_accum_d     = hex_accum_q;
    name_length_d   = name_length_q;
    region_left_d   = region_left_q;
    name_seen_d     = name_seen_q;
    data_left_d     = data_left_q;
    pad_left_d      = pad_left_q;
    trailer_match_d = trailer_match_q;
    error_kind_d    = error_kind_q;
    raise           = cnsd_pkg::ErrNone;

    result_o.kind        = cnsd_pkg::KindError;
    result_o.field_index = 4'd0;
    result_o.value       = {24'd0, byte_i};
    result_o.is_trailer  = 1'b0;
    result_o.error_code  = cnsd_pkg::ErrNone;

    unique case (phase_q)
      cnsd_pkg::PhHeader: begin
        if (header_pos_q < 7'(cnsd_pkg::MagicLen)) begin
          if (byte_i != cnsd_pkg::MagicPat[header_pos_q[2:0]]) begin
            raise = cnsd_pkg::ErrBadMagic;
          end else begin
            result_o.kind = cnsd_pkg::KindDigit;
            header_pos_d  = header_pos_q + 7'd1;
          end
        end else if (!hex[4]) begin
          raise = cnsd_pkg::ErrBadDigit;
        end else if (hdr_k[2:0] != 3'd7) begin
          result_o.kind = cnsd_pkg::KindDigit;
          hex_accum_d   = accum_next;
          header_pos_d  = header_pos_q + 7'd1;
        end else begin
          result_o.kind        = cnsd_pkg::KindFieldDone;
          result_o.field_index = hdr_k[6:3];
          result_o.value       = accum_next;
          hex_accum_d          = 32'd0;
          header_pos_d         = header_pos_q + 7'd1;
          if (hdr_k[6:3] == cnsd_pkg::FieldFileSize) data_left_d = accum_next;
          if (hdr_k[6:3] == cnsd_pkg::FieldNameSize) name_length_d = accum_next;
          if (hdr_k[6:3] >= cnsd_pkg::FieldLast) begin
            if (fsz > 34'(MAX_NAME_REGION)) begin
              raise = cnsd_pkg::ErrNameLong;
            end else begin
              region_left_d   = fsz[RW-1:0];
              name_seen_d     = '0;
              trailer_match_d = 1'b1;
              header_pos_d    = 7'd0;
              phase_d         = cnsd_pkg::PhName;
            end
          end
        end
      end
      cnsd_pkg::PhName: begin
        result_o.kind   = ({{(32-RW){1'b0}}, name_seen_q} < name_length_q) ?
                          cnsd_pkg::KindNameByte : cnsd_pkg::KindNamePad;
        trailer_match_d = tm_next;
        name_seen_d     = name_seen_q + RW'(1);
        region_left_d   = region_dec;
        if (region_dec == '0) begin
          if (tm_next && name_seen_q >= RW'(cnsd_pkg::TrailerLen - 1)) begin
            result_o.is_trailer = 1'b1;
            phase_d             = cnsd_pkg::PhEnded;
          end else begin
            pad_left_d = pad_after_name;
            if (data_left_q != '0) begin
              phase_d = cnsd_pkg::PhData;
            end else if (pad_after_name != 2'd0) begin
              phase_d = cnsd_pkg::PhPad;
            end else begin
              phase_d      = cnsd_pkg::PhHeader;
              header_pos_d = 7'd0;
              hex_accum_d  = 32'd0;
            end
          end
        end
      end
      cnsd_pkg::PhData: begin
        result_o.kind = cnsd_pkg::KindDataByte;
        data_left_d   = data_dec;
        if (data_dec == '0) begin
          if (pad_left_q != 2'd0) begin
            phase_d = cnsd_pkg::PhPad;
          end else begin
            phase_d      = cnsd_pkg::PhHeader;
            header_pos_d = 7'd0;
            hex_accum_d  = 32'd0;
          end
        end
      end
      cnsd_pkg::PhPad: begin
        result_o.kind = cnsd_pkg::KindDataPad;
        pad_left_d    = pad_left_q - 2'd1;
        if (pad_left_q == 2'd1) begin
          phase_d      = cnsd_pkg::PhHeader;
          header_pos_d = 7'd0;
          hex_accum_d  = 32'd0;
        end
      end
      cnsd_pkg::PhEnded: begin
        result_o.kind = cnsd_pkg::KindEnded;
      end
      default: begin
        result_o.kind = cnsd_pkg::KindError;
      end
    endcase

    if (raise != cnsd_pkg::ErrNone) begin
      error_kind_d         = raise;
      phase_d              = cnsd_pkg::PhError;
      result_o.kind        = cnsd_pkg::KindError;
      result_o.field_index = 4'd0;
      result_o.value       = {24'd0, byte_i};
    end

    if (result_o.kind == cnsd_pkg::KindError) result_o.error_code = error_kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= cnsd_pkg::PhHeader;
      header_pos_q    <= '0;
      hex_accum_q     <= '0;
      name_length_q   <= '0;
      region_left_q   <= '0;
      name_seen_q     <= '0;
      data_left_q     <= '0;
      pad_left_q      <= '0;
      trailer_match_q <= 1'b1;
      error_kind_q    <= cnsd_pkg::ErrNone;
    end else if (step_i) begin
      phase_q         <= phase_d;
      header_pos_q    <= header_pos_d;
      hex_accum_q     <= hex_accum_d;
      name_length_q   <= name_length_d;
      region_left_q   <= region_left_d;
      name_seen_q     <= name_seen_d;
      data_left_q     <= data_left_d;
      pad_left_q      <= pad_left_d;
      trailer_match_q <= trailer_match_d;
      error_kind_q    <= error_kind_d;
    end
  end

endmodule

// ===== bench/cpio_newc_stream_deframer_top_tb.sv =====
`timescale 1ns / 1ps

module cpio_newc_stream_deframer_top_tb;

  localparam int unsigned NameRegionMax = 4096;
  localparam int unsigned BodyBytes     = 400;
  localparam int unsigned CycleLimit    = 2_000_000;

  localparam logic [47:0] MagicStr   = "070701";
  localparam logic [87:0] TrailerStr = {"TRAILER!!!", 8'h00};

  typedef enum int {FillRandom, FillZero, FillOnes} fill_e;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  cpio_newc_stream_deframer_top #(
    .MAX_NAME_REGION(NameRegionMax)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // parser state mirror
  cnsd_pkg::phase_e st_phase    = cnsd_pkg::PhHeader;
  logic [6:0]  st_hdr_pos     = '0;
  logic [31:0] st_acc         = '0;
  logic [31:0] st_name_len    = '0;
  logic [12:0] st_region_left = '0;
  logic [12:0] st_name_seen   = '0;
  logic [31:0] st_data_left   = '0;
  logic [1:0]  st_pad_left    = '0;
  logic        st_trailer_ok  = 1'b1;
  logic [1:0]  st_err_code    = cnsd_pkg::ErrNone;

  cnsd_pkg::result_t byte_reports[$];
  logic [7:0]  entry_bytes[$];
  int unsigned mismatches  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned cycles      = 0;
  bit          sender_quiet = 1'b0;

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
    if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h61 + 8'd10)};
    if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic int unsigned idle_len(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic restart_header();
    st_phase   = cnsd_pkg::PhHeader;
    st_hdr_pos = '0;
    st_acc     = '0;
  endtask

  task automatic classify_byte(input logic [7:0] b);
    cnsd_pkg::result_t r;
    logic [1:0]  raise;
    logic [4:0]  d;
    logic [6:0]  k;
    logic [33:0] region;
    logic [12:0] p;
    r       = '0;
    r.kind  = cnsd_pkg::KindError;
    r.value = {24'h0, b};
    raise   = cnsd_pkg::ErrNone;
    case (st_phase)
      cnsd_pkg::PhHeader: begin
        if (st_hdr_pos < 7'd6) begin
          if (b != MagicStr[47 - 8 * int'(st_hdr_pos) -: 8]) begin
            raise = cnsd_pkg::ErrBadMagic;
          end else begin
            r.kind = cnsd_pkg::KindDigit;
            st_hdr_pos++;
          end
        end else begin
          d = hex_nibble(b);
          k = st_hdr_pos - 7'd6;
          if (!d[4]) begin
            raise = cnsd_pkg::ErrBadDigit;
          end else begin
            st_acc = {st_acc[27:0], d[3:0]};
            if (k[2:0] != 3'd7) begin
              r.kind = cnsd_pkg::KindDigit;
              st_hdr_pos++;
            end else begin
              r.kind        = cnsd_pkg::KindFieldDone;
              r.field_index = k[6:3];
              r.value       = st_acc;
              st_acc        = '0;
              st_hdr_pos++;
              if (r.field_index == cnsd_pkg::FieldFileSize) st_data_left = r.value;
              if (r.field_index == cnsd_pkg::FieldNameSize) st_name_len = r.value;
              if (r.field_index >= cnsd_pkg::FieldLast) begin
                region = ((34'(st_name_len) + 34'd1) & ~34'd3) + 34'd2;
                if (region > NameRegionMax) begin
                  raise = cnsd_pkg::ErrNameLong;
                end else begin
                  st_region_left = region[12:0];
                  st_name_seen   = '0;
                  st_trailer_ok  = 1'b1;
                  st_hdr_pos     = '0;
                  st_phase       = cnsd_pkg::PhName;
                end
              end
            end
          end
        end
      end
      cnsd_pkg::PhName: begin
        p = st_name_seen;
        r.kind = (32'(p) < st_name_len) ? cnsd_pkg::KindNameByte : cnsd_pkg::KindNamePad;
        if (p < 13'd11) begin
          if (b != TrailerStr[87 - 8 * int'(p) -: 8]) st_trailer_ok = 1'b0;
        end
        st_name_seen++;
        if (st_region_left != 0) st_region_left--;
        if (st_region_left == 0) begin
          if (st_trailer_ok && p >= 13'd10) begin
            r.is_trailer = 1'b1;
            st_phase     = cnsd_pkg::PhEnded;
          end else begin
            st_pad_left = 2'(~st_data_left + 32'd1);
            if (st_data_left != 0) st_phase = cnsd_pkg::PhData;
            else if (st_pad_left != 0) st_phase = cnsd_pkg::PhPad;
            else restart_header();
          end
        end
      end
      cnsd_pkg::PhData: begin
        r.kind = cnsd_pkg::KindDataByte;
        if (st_data_left != 0) st_data_left--;
        if (st_data_left == 0) begin
          if (st_pad_left != 0) st_phase = cnsd_pkg::PhPad;
          else restart_header();
        end
      end
      cnsd_pkg::PhPad: begin
        r.kind = cnsd_pkg::KindDataPad;
        st_pad_left = st_pad_left - 2'd1;
        if (st_pad_left == 0) restart_header();
      end
      cnsd_pkg::PhEnded: r.kind = cnsd_pkg::KindEnded;
      default: r.kind = cnsd_pkg::KindError;
    endcase
    if (raise != cnsd_pkg::ErrNone) begin
      st_err_code   = raise;
      st_phase      = cnsd_pkg::PhError;
      r.kind        = cnsd_pkg::KindError;
      r.field_index = '0;
      r.value       = {24'h0, b};
    end
    r.error_code = (r.kind == cnsd_pkg::KindError) ? st_err_code : cnsd_pkg::ErrNone;
    byte_reports.push_back(r);
  endtask

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_len(sender_quiet);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    classify_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic build_entry(input logic [31:0] name_size, input logic [31:0] file_size,
                             input fill_e fill, input string name_txt);
    logic [31:0] fld;
    logic [33:0] region;
    logic [7:0]  b;
    int unsigned i;
    int          f, j;
    entry_bytes.delete();
    for (i = 0; i < 6; i++) entry_bytes.push_back(MagicStr[47 - 8 * i -: 8]);
    for (f = 0; f < 13; f++) begin
      case (f)
        cnsd_pkg::FieldFileSize: fld = file_size;
        cnsd_pkg::FieldNameSize: fld = name_size;
        default: fld = (fill == FillZero) ? 32'h0 : (fill == FillOnes) ? '1 : $urandom();
      endcase
      for (j = 7; j >= 0; j--) begin
        entry_bytes.push_back(hex_char(fld[4 * j +: 4], 1'($urandom_range(0, 1))));
      end
    end
    region = ((34'(name_size) + 34'd1) & ~34'd3) + 34'd2;
    if (region <= NameRegionMax) begin
      for (i = 0; i < region; i++) begin
        if (i < name_txt.len()) b = name_txt[i];
        else if (i + 1 < name_size) b = 8'($urandom_range(1, 255));
        else if (i + 1 == name_size) b = 8'h00;
        else b = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'h00;
        entry_bytes.push_back(b);
      end
      for (i = 0; i < file_size; i++) begin
        case (fill)
          FillZero: b = 8'h00;
          FillOnes: b = 8'hff;
          default:  b = 8'($urandom());
        endcase
        entry_bytes.push_back(b);
      end
      for (i = 0; i < ((32'd0 - file_size) & 32'd3); i++) begin
        entry_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'h00);
      end
    end
  endtask

  task automatic send_entry();
    sender_quiet = ($urandom_range(0, 4) == 0);
    foreach (entry_bytes[i]) send_byte(entry_bytes[i]);
  endtask

  task automatic test_directed_entries();
    // empty name, no data, all-ones fields
    build_entry(32'd0, 32'd0, FillOnes, "");
    send_entry();
    // region too short to be the trailer
    build_entry(32'd7, 32'd1, FillZero, "TRAILER!!!");
    send_entry();
    // trailer text without its NUL
    build_entry(32'd12, 32'd2, FillRandom, "TRAILER!!!X");
    send_entry();
  endtask

  task automatic test_random_archive();
    logic [31:0] ns, fs;
    while (bytes_sent < BodyBytes) begin
      ns = $urandom_range(0, 20);
      fs = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      build_entry(ns, fs, FillRandom, "");
      send_entry();
    end
  endtask

  task automatic test_archive_end();
    int unsigned pos;
    logic [7:0]  nb;
    logic [4:0]  d;
    logic [31:0] ns;
    case ($urandom_range(0, 3))
      0: begin
        // trailer, its file size is left unconsumed
        build_entry(32'd11, $urandom_range(0, 9), FillRandom, "TRAILER!!!");
      end
      1: begin
        build_entry($urandom_range(0, 20), $urandom_range(0, 12), FillRandom, "");
        pos = $urandom_range(0, 5);
        entry_bytes[pos] = entry_bytes[pos] ^ 8'($urandom_range(1, 255));
      end
      2: begin
        build_entry($urandom_range(0, 20), $urandom_range(0, 12), FillRandom, "");
        pos = $urandom_range(6, 109);
        do begin
          nb = 8'($urandom());
          d  = hex_nibble(nb);
        end while (d[4]);
        entry_bytes[pos] = nb;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: ns = 32'd4095;
          1: ns = 32'hffff_ffff;
          default: ns = $urandom_range(4096, 32'hffff_fff0);
        endcase
        build_entry(ns, $urandom_range(0, 12), FillRandom, "");
      end
    endcase
    send_entry();
    repeat ($urandom_range(8, 16)) send_byte(8'($urandom()));
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    cnsd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (byte_reports.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual tuser=%0h tdata=%0h tlast=%0b",
                 $time, m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = byte_reports.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser_o));
        check_field("field_index", 32'(want.field_index), 32'(m_axis_tdata_o[3:0]));
        check_field("value", want.value, m_axis_tdata_o[35:4]);
        check_field("error_code", 32'(want.error_code), 32'(m_axis_tdata_o[37:36]));
        check_field("tdata pad", 32'd0, 32'(m_axis_tdata_o[39:38]));
        check_field("is_trailer", 32'(want.is_trailer), 32'(m_axis_tlast_o));
      end
    end
  end

  initial begin
    int unsigned stall_left;
    bit          calm;
    stall_left = 0;
    calm       = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 149) == 0) calm = !calm;
      if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) stall_left = idle_len(1'b0);
      if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** cpio_newc_stream_deframer_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_entries();
    test_random_archive();
    test_archive_end();
    s_axis_tvalid_i <= 1'b0;
    while (byte_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** cpio_newc_stream_deframer_top: PASSED **");
    end else begin
      $display("** cpio_newc_stream_deframer_top: FAILED **");
    end
    $finish;
  end

endmodule
